// ===== rtl/utf8v_pkg.sv =====
// types and constants shared by the utf-8 stream validator
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] MIN_CP_LEN2 = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP_LEN3 = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP_LEN4 = 21'h10000;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic       last;
        logic       is_cont;
        logic       lead_bad;
        logic [1:0] need;
        logic [4:0] lead_val;
        logic [5:0] cont_val;
    } utf8v_item_t;

endpackage

// ===== rtl/utf8v_if.sv =====
// handshake channels of the utf-8 stream validator
`timescale 1ns / 1ps

interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_verdict_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

// ===== rtl/utf8_stream_validator.sv =====
// Checks a byte stream for well-formed UTF-8, one buffer at a time. Bytes
// arrive on byte_ch with last_byte marking the end of a buffer; exactly one
// verdict per buffer leaves on verdict_ch, is_valid high when the buffer is
// acceptable. A sequence cut short by the end of the buffer is accepted;
// overlong forms, surrogates, code points above U+10FFFF, bad lead bytes and
// bad continuation bytes are rejected. One byte is taken every clock cycle
// for as long as verdicts are collected; the final byte of a buffer passes
// through the queue before the verdict register is loaded. A front
// classifier feeds a FIFO_DEPTH entry queue so the input keeps flowing while
// the verdict register is stalled, until the queue fills.
`timescale 1ns / 1ps

module utf8_stream_validator #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    utf8v_byte_if.sink      byte_ch,
    utf8v_verdict_if.source verdict_ch
);
    import utf8v_pkg::*;

    utf8v_item_t front_item;
    utf8v_item_t head_item;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    utf8v_front u_front (
        .byte_ch (byte_ch),
        .full    (full),
        .push    (push),
        .item    (front_item)
    );

    utf8v_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (head_item),
        .empty     (empty)
    );

    utf8v_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head_item),
        .pop        (pop),
        .verdict_ch (verdict_ch)
    );

endmodule

// ===== rtl/utf8v_front.sv =====
// front end: accepts bytes and classifies them as lead or continuation
`timescale 1ns / 1ps

module utf8v_front (
    utf8v_byte_if.sink          byte_ch,
    input  logic                full,
    output logic                push,
    output utf8v_pkg::utf8v_item_t item
);
    import utf8v_pkg::*;

    logic [7:0] b;

    assign b             = byte_ch.data_byte;
    assign byte_ch.ready = !full;
    assign push          = byte_ch.valid && !full;

    always_comb
    begin
        item.last     = byte_ch.last_byte;
        item.is_cont  = (b[7:6] == 2'b10);
        item.cont_val = b[5:0];
        item.lead_bad = 1'b0;
        item.need     = NEED_NONE;
        item.lead_val = 5'd0;
        case (b) inside
            [8'h00:8'h7F]:
            begin
                item.need = NEED_NONE;
            end
            [8'hC2:8'hDF]:
            begin
                item.need     = NEED_ONE;
                item.lead_val = b[4:0];
            end
            [8'hE0:8'hEF]:
            begin
                item.need     = NEED_TWO;
                item.lead_val = {1'b0, b[3:0]};
            end
            [8'hF0:8'hF4]:
            begin
                item.need     = NEED_THREE;
                item.lead_val = {2'b00, b[2:0]};
            end
            default:
            begin
                // lone continuation, c0, c1 and f5 upwards
                item.lead_bad = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/utf8v_fifo.sv =====
// short queue of classified items between front and back
`timescale 1ns / 1ps

module utf8v_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  utf8v_pkg::utf8v_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output utf8v_pkg::utf8v_item_t pop_item,
    output logic                   empty
);
    import utf8v_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    utf8v_item_t   mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/utf8v_back.sv =====
// back end: sequence tracking, range checks and verdict register
`timescale 1ns / 1ps

module utf8v_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   empty,
    input  utf8v_pkg::utf8v_item_t head,
    output logic                   pop,
    utf8v_verdict_if.source        verdict_ch
);
    import utf8v_pkg::*;

    logic [1:0]      slots_reg, slots_next;
    logic [1:0]      len_reg, len_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic            pb_reg, pb_next;
    logic            failed_reg, failed_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_bit_reg, out_bit_next;

    logic [CP_W-1:0] acc_shift;
    logic [CP_W-1:0] min_cp;
    logic            pb_cur;
    logic            seq_bad;

    // a final byte waits only while an undelivered verdict holds the register
    assign pop = !empty && (!head.last || !out_valid_reg || verdict_ch.ready);

    assign acc_shift = {acc_reg[CP_W-7:0], head.cont_val};
    assign pb_cur    = pb_reg || !head.is_cont;

    always_comb
    begin
        case (len_reg)
            NEED_ONE: min_cp = MIN_CP_LEN2;
            NEED_TWO: min_cp = MIN_CP_LEN3;
            default:  min_cp = MIN_CP_LEN4;
        endcase
    end

    assign seq_bad = pb_cur || (acc_shift < min_cp) ||
                     ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI)) ||
                     (acc_shift > CP_MAX);

    always_comb
    begin
        slots_next     = slots_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        pb_next        = pb_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !verdict_ch.ready;
        out_bit_next   = out_bit_reg;
        if (pop)
        begin
            if (!failed_reg)
            begin
                if (slots_reg == NEED_NONE)
                begin
                    if (head.lead_bad)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (head.need != NEED_NONE)
                    begin
                        slots_next = head.need;
                        len_next   = head.need;
                        acc_next   = {{(CP_W-5){1'b0}}, head.lead_val};
                        pb_next    = 1'b0;
                    end
                end
                else
                begin
                    slots_next = slots_reg - 1'b1;
                    acc_next   = acc_shift;
                    pb_next    = pb_cur;
                    if (slots_reg == NEED_ONE)
                    begin
                        failed_next = seq_bad;
                        pb_next     = 1'b0;
                        len_next    = NEED_NONE;
                        acc_next    = '0;
                    end
                end
            end
            if (head.last)
            begin
                out_valid_next = 1'b1;
                out_bit_next   = !failed_next;
                slots_next     = NEED_NONE;
                len_next       = NEED_NONE;
                acc_next       = '0;
                pb_next        = 1'b0;
                failed_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= NEED_NONE;
            len_reg       <= NEED_NONE;
            acc_reg       <= '0;
            pb_reg        <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg     <= slots_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            pb_reg        <= pb_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
    end

    assign verdict_ch.valid    = out_valid_reg;
    assign verdict_ch.is_valid = out_bit_reg;

endmodule

// ===== rtl/utf8v_checker.sv =====
// port-level checks of the utf-8 stream validator
`timescale 1ns / 1ps

module utf8v_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_is_valid
);

    // buffers whose final byte went in but whose verdict has not come out
    logic [7:0] open_reg, open_next;
    logic       end_in;
    logic       verdict_out;

    assign end_in      = in_valid && in_ready && in_last;
    assign verdict_out = out_valid && out_ready;

    always_comb
    begin
        open_next = open_reg;
        if (end_in && !verdict_out)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (verdict_out && !end_in)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("verdict dropped while stalled");

    a_verdict_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_is_valid))
        else $error("verdict changed while stalled");

    a_verdict_has_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 8'd0)
        else $error("verdict without a finished buffer");

    a_no_early_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        end_in && open_reg == 8'd0 |=> !out_valid)
        else $error("verdict appeared in the cycle after the final byte");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_ch.valid),
    .in_ready     (byte_ch.ready),
    .in_last      (byte_ch.last_byte),
    .out_valid    (verdict_ch.valid),
    .out_ready    (verdict_ch.ready),
    .out_is_valid (verdict_ch.is_valid)
);

// ===== dv/utf8_stream_validator_tb.sv =====
// self-checking testbench for the utf-8 stream validator
`timescale 1ns / 1ps

module utf8_stream_validator_tb;

    localparam logic [20:0] LIM_LEN2  = 21'h00080;
    localparam logic [20:0] LIM_LEN3  = 21'h00800;
    localparam logic [20:0] LIM_LEN4  = 21'h10000;
    localparam logic [20:0] SURR_BASE = 21'h0D800;
    localparam logic [20:0] SURR_TOP  = 21'h0DFFF;
    localparam logic [20:0] CODE_TOP  = 21'h10FFFF;
    localparam int          RANDOM_BYTES_PER_PHASE = 220;

    logic clk;
    logic rst_n;

    utf8v_byte_if    byte_ch ();
    utf8v_verdict_if verdict_ch ();

    utf8_stream_validator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .verdict_ch (verdict_ch)
    );

    // predicted decoder state
    logic [1:0]  dec_slots;
    logic [1:0]  dec_len;
    logic [20:0] dec_code;
    logic        dec_cont_bad;
    logic        dec_failed;

    logic        verdict_q[$];
    logic [7:0]  buf_q[$];
    logic        exp_verdict;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_len;
    bit hold_on;

    int mismatch_count;
    int bytes_sent;
    int buffers_sent;
    int good_verdicts;
    int bad_verdicts;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic clear_decoder();
        dec_slots    = 2'd0;
        dec_len      = 2'd0;
        dec_code     = 21'd0;
        dec_cont_bad = 1'b0;
        dec_failed   = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [1:0]  need;
        logic        bad;
        logic [20:0] lim;
        if (!dec_failed)
        begin
            if (dec_slots == 2'd0)
            begin
                need = 2'd0;
                bad  = 1'b0;
                if (b[7] == 1'b0)
                    need = 2'd0;
                else if (b[7:5] == 3'b110)
                begin
                    need = 2'd1;
                    bad  = (b < 8'hC2);
                end
                else if (b[7:4] == 4'b1110)
                    need = 2'd2;
                else if (b[7:3] == 5'b11110)
                begin
                    need = 2'd3;
                    bad  = (b > 8'hF4);
                end
                else
                    bad = 1'b1;
                if (bad)
                    dec_failed = 1'b1;
                else if (need != 2'd0)
                begin
                    dec_slots    = need;
                    dec_len      = need;
                    dec_code     = {13'd0, b & (8'h7F >> need)};
                    dec_cont_bad = 1'b0;
                end
            end
            else
            begin
                if (b[7:6] != 2'b10)
                    dec_cont_bad = 1'b1;
                dec_code  = {dec_code[14:0], b[5:0]};
                dec_slots = dec_slots - 2'd1;
                if (dec_slots == 2'd0)
                begin
                    case (dec_len)
                        2'd1:    lim = LIM_LEN2;
                        2'd2:    lim = LIM_LEN3;
                        default: lim = LIM_LEN4;
                    endcase
                    if (dec_cont_bad || dec_code < lim ||
                        (dec_code >= SURR_BASE && dec_code <= SURR_TOP) ||
                        dec_code > CODE_TOP)
                        dec_failed = 1'b1;
                    dec_cont_bad = 1'b0;
                    dec_len      = 2'd0;
                    dec_code     = 21'd0;
                end
            end
        end
        if (last)
        begin
            verdict_q.push_back(!dec_failed);
            clear_decoder();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        int n;
        n = buf_q.size();
        for (int i = 0; i < n; i++)
            send_byte(buf_q[i], i == n - 1);
        buf_q.delete();
        buffers_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] encode_code(input logic [20:0] cp, input int len);
        case (len)
            1:       return {1'b0, cp[6:0], 24'd0};
            2:       return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
            3:       return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]};
        endcase
    endfunction

    task automatic push_char();
        int          kind;
        int          len;
        int          keep;
        int          spoil;
        logic [20:0] cp;
        logic [31:0] enc;
        logic [7:0]  b;
        kind  = $urandom_range(99);
        len   = $urandom_range(2, 4);
        keep  = len;
        spoil = 0;
        if (kind < 25)
        begin
            len = 1;
            cp  = 21'($urandom_range(127));
        end
        else if (kind < 70)
        begin
            // well-formed multi-byte character
            case (len)
                2:       cp = 21'($urandom_range(32'h7FF, 32'h80));
                3:       cp = 21'($urandom_range(32'hFFFF, 32'h800));
                default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
            endcase
            if (len == 3 && cp >= SURR_BASE && cp <= SURR_TOP)
                cp = 21'($urandom_range(32'hFFFF, 32'hE000));
        end
        else if (kind < 76)
        begin
            // overlong form
            case (len)
                2:       cp = 21'($urandom_range(32'h7F));
                3:       cp = 21'($urandom_range(32'h7FF));
                default: cp = 21'($urandom_range(32'hFFFF));
            endcase
        end
        else if (kind < 80)
        begin
            len = 3;
            cp  = 21'($urandom_range(32'hDFFF, 32'hD800));
        end
        else if (kind < 84)
        begin
            len = 4;
            cp  = 21'($urandom_range(32'h1FFFFF, 32'h110000));
        end
        else if (kind < 90)
        begin
            cp    = 21'($urandom_range(32'h10FFFF, 32'h80));
            spoil = $urandom_range(len - 1, 1);
        end
        else if (kind < 95)
        begin
            buf_q.push_back(8'($urandom_range(255)));
            return;
        end
        else
        begin
            // truncated sequence
            cp   = 21'($urandom_range(32'h10FFFF, 32'h80));
            keep = $urandom_range(len - 1, 1);
        end
        if (len == 1)
            keep = 1;
        enc = encode_code(cp, len);
        for (int i = 0; i < keep; i++)
        begin
            b = enc[31 - 8 * i -: 8];
            if (i == spoil && spoil != 0)
            begin
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
            end
            buf_q.push_back(b);
        end
    endtask

    task automatic test_single_bytes_and_bad_leads();
        buf_q = '{8'h7F, 8'h00};
        send_buffer();
        buf_q = '{8'h80};
        send_buffer();
        buf_q = '{8'hC1, 8'h80};
        send_buffer();
        buf_q = '{8'hC0};
        send_buffer();
        buf_q = '{8'hFF};
        send_buffer();
    endtask

    task automatic test_sequence_errors();
        buf_q = '{8'hC2, 8'h41};
        send_buffer();
        buf_q = '{8'hE0, 8'h80, 8'h80};
        send_buffer();
        buf_q = '{8'hED, 8'hA0, 8'h80};
        send_buffer();
        buf_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_buffer();
        buf_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer();
    endtask

    task automatic test_cut_short_and_skip();
        buf_q = '{8'hE2};
        send_buffer();
        // error early, rest ignored
        buf_q = '{8'hF5, 8'hC2};
        send_buffer();
    endtask

    task automatic test_random_streams(input int idle_pct, input int stall_pct);
        int start;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start          = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES_PER_PHASE)
        begin
            repeat ($urandom_range(6, 1)) push_char();
            send_buffer();
        end
    endtask

    task automatic test_fill_and_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = 300;
        repeat (60)
        begin
            buf_q.push_back(8'($urandom_range(255)));
            send_buffer();
        end
        wait_for_drain();
    endtask

    // long receiver hold-off
    initial
    begin
        hold_on  = 1'b0;
        hold_len = 0;
        forever
        begin
            wait (hold_len > 0);
            hold_on = 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_on  = 1'b0;
            hold_len = 0;
        end
    end

    initial
    begin
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_on)
                verdict_ch.ready <= 1'b0;
            else
                verdict_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("verdict with no buffer pending");
            else
            begin
                exp_verdict = verdict_q.pop_front();
                if (verdict_ch.is_valid !== exp_verdict)
                    report_mismatch($sformatf("is_valid %b, expected %b",
                                              verdict_ch.is_valid, exp_verdict));
            end
            if (verdict_ch.is_valid === 1'b1)
                good_verdicts++;
            else
                bad_verdicts++;
        end
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d verdicts outstanding", verdict_q.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        mismatch_count    = 0;
        bytes_sent        = 0;
        buffers_sent      = 0;
        good_verdicts     = 0;
        bad_verdicts      = 0;
        clear_decoder();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes_and_bad_leads();
        test_sequence_errors();
        test_cut_short_and_skip();
        wait_for_drain();
        test_random_streams(0, 0);
        test_random_streams(76, 0);
        test_random_streams(0, 76);
        test_random_streams(28, 28);
        test_fill_and_stall();
        test_random_streams(28, 28);

        @(negedge clk);
        byte_ch.valid <= 1'b0;
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

        $display("%0d bytes in %0d buffers checked: %0d accepted, %0d rejected",
                 bytes_sent, buffers_sent, good_verdicts, bad_verdicts);
        $display("phases: no idling, sender idle, receiver stalls, both, long hold-off");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
